// ===== hdl/pbrd_pkg.sv =====
// Shared types and constants for the PackBits row decoder.
// No dependencies; imported by pbrd_decode and packbits_row_decoder.
`default_nettype none

package pbrd_pkg;

   // Stride above this value selects the two-byte length prefix
   localparam logic [13:0] PREFIX_WIDE_ABOVE = 14'd250;
   // Header code that means "no operation"
   localparam logic [7:0]  NOOP_HEADER       = 8'h80;
   // Saturation limit of the consumed byte counter
   localparam logic [16:0] CONSUMED_MAX      = 17'h1FFFF;

   // Configuration register indexes
   localparam logic CSR_ROW_STRIDE = 1'b0;
   localparam logic CSR_WIDE_ELEM  = 1'b1;

   typedef enum logic [2:0] {
      PH_LEN_FIRST,
      PH_LEN_SECOND,
      PH_HEADER,
      PH_LITERAL,
      PH_RUN
   } phase_type;

   typedef struct packed {
      logic [13:0] row_stride_bytes;
      logic        wide_elements;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] elem_value;
      logic [7:0]  repeat_count;
      logic        row_end;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/pbrd_decode.sv =====
// Decode state and single-pass byte decode for the PackBits row decoder.
// Depends on pbrd_pkg (phase type, config and result structs).
`default_nettype none

module pbrd_decode
   import pbrd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] in_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] decl_len_ff, decl_len_in;
   logic [16:0] consumed_ff, consumed_in;
   logic [7:0]  elem_left_ff, elem_left_in;
   logic [7:0]  pend_high_ff, pend_high_in;
   logic        second_half_ff, second_half_in;

   logic        wide_prefix;
   logic [15:0] first_len;
   logic [15:0] second_len;
   logic [16:0] consumed_inc;
   logic        reach_inc;
   logic        elem_done;
   logic [15:0] elem_value;
   logic [7:0]  lit_left;
   logic [7:0]  run_count;

   // Shared decode terms
   assign wide_prefix  = cfg.row_stride_bytes > PREFIX_WIDE_ABOVE;
   assign first_len    = {8'h00, in_byte};
   assign second_len   = {decl_len_ff[15:8], in_byte};
   assign consumed_inc = (consumed_ff < CONSUMED_MAX) ? consumed_ff + 17'd1 : consumed_ff;
   assign reach_inc    = consumed_inc >= {1'b0, decl_len_ff};
   assign elem_done    = !(cfg.wide_elements && !second_half_ff);
   assign elem_value   = cfg.wide_elements ? {pend_high_ff, in_byte} : {8'h00, in_byte};
   assign lit_left     = (elem_left_ff == 8'd0) ? 8'd0 : elem_left_ff - 8'd1;
   // 257 - header, always 2..128 for a run header
   assign run_count    = 8'(9'd257 - {1'b0, in_byte});

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      decl_len_in    = decl_len_ff;
      consumed_in    = consumed_ff;
      elem_left_in   = elem_left_ff;
      pend_high_in   = pend_high_ff;
      second_half_in = second_half_ff;
      if (step) begin
         case (phase_ff)
            PH_LEN_FIRST: begin
               if (wide_prefix) begin
                  decl_len_in = {in_byte, 8'h00};
                  phase_in    = PH_LEN_SECOND;
               end else begin
                  decl_len_in = first_len;
                  consumed_in = '0;
                  if (first_len == 16'd0) begin
                     phase_in = PH_LEN_FIRST;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_LEN_SECOND: begin
               decl_len_in = second_len;
               consumed_in = '0;
               if (second_len == 16'd0) begin
                  phase_in = PH_LEN_FIRST;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               consumed_in    = consumed_inc;
               second_half_in = 1'b0;
               if (in_byte < NOOP_HEADER) begin
                  elem_left_in = in_byte + 8'd1;
                  phase_in     = PH_LITERAL;
               end else if (in_byte != NOOP_HEADER) begin
                  elem_left_in = run_count;
                  phase_in     = PH_RUN;
               end else if (reach_inc) begin
                  phase_in       = PH_LEN_FIRST;
                  decl_len_in    = '0;
                  consumed_in    = '0;
                  elem_left_in   = '0;
                  pend_high_in   = '0;
               end
            end
            PH_LITERAL, PH_RUN: begin
               consumed_in = consumed_inc;
               if (!elem_done) begin
                  pend_high_in   = in_byte;
                  second_half_in = 1'b1;
               end else begin
                  pend_high_in   = '0;
                  second_half_in = 1'b0;
                  elem_left_in   = (phase_ff == PH_LITERAL) ? lit_left : 8'd0;
                  if (phase_ff == PH_RUN || lit_left == 8'd0) begin
                     if (reach_inc) begin
                        // row done: back to the length prefix
                        phase_in     = PH_LEN_FIRST;
                        decl_len_in  = '0;
                        consumed_in  = '0;
                        elem_left_in = '0;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
            end
            default: begin
               phase_in       = PH_LEN_FIRST;
               decl_len_in    = '0;
               consumed_in    = '0;
               elem_left_in   = '0;
               pend_high_in   = '0;
               second_half_in = 1'b0;
            end
         endcase
      end
   end

   // Result word for the current byte
   always_comb begin
      result = '0;
      case (phase_ff)
         PH_LEN_FIRST: begin
            result.valid   = !wide_prefix && (first_len == 16'd0);
            result.row_end = 1'b1;
         end
         PH_LEN_SECOND: begin
            result.valid   = second_len == 16'd0;
            result.row_end = 1'b1;
         end
         PH_HEADER: begin
            result.valid   = (in_byte == NOOP_HEADER) && reach_inc;
            result.row_end = 1'b1;
         end
         PH_LITERAL: begin
            result.valid        = elem_done;
            result.elem_value   = elem_value;
            result.repeat_count = 8'd1;
            result.row_end      = (lit_left == 8'd0) && reach_inc;
         end
         PH_RUN: begin
            result.valid        = elem_done;
            result.elem_value   = elem_value;
            result.repeat_count = elem_left_ff;
            result.row_end      = reach_inc;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN_FIRST;
         decl_len_ff    <= '0;
         consumed_ff    <= '0;
         elem_left_ff   <= '0;
         pend_high_ff   <= '0;
         second_half_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         decl_len_ff    <= decl_len_in;
         consumed_ff    <= consumed_in;
         elem_left_ff   <= elem_left_in;
         pend_high_ff   <= pend_high_in;
         second_half_ff <= second_half_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/packbits_row_decoder.sv =====
// PackBits row decoder: one compressed byte per word in, at most one decoded word out.
// Path: a byte waits in the input register; its decoded word goes to the result register.
// Throughput: one byte per cycle unless rsp_stall holds; counters step per decoded byte.
// Reset: synchronous, active high; clears control and decode state, waits for a length prefix.
// Top level: input register, config registers, result register; uses pbrd_decode, pbrd_pkg.
`default_nettype none

module packbits_row_decoder
   import pbrd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_elem_value,
   output logic [7:0]       rsp_repeat_count,
   output logic             rsp_row_end,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [13:0] csr_wr_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   result_type  dec_result;
   logic        advance;
   logic        accept;

   // Decode runs when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance ? dec_result.valid : (rsp_valid_ff & rsp_stall);

   // Config register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_STRIDE: cfg_in.row_stride_bytes = csr_wr_data;
            CSR_WIDE_ELEM:  cfg_in.wide_elements    = csr_wr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   pbrd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (dec_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         rsp_ff <= dec_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_elem_value   = rsp_ff.elem_value;
   assign rsp_repeat_count = rsp_ff.repeat_count;
   assign rsp_row_end      = rsp_ff.row_end;

endmodule

`default_nettype wire
